[rtl/tkfv_pkg.sv]
// Package with the sizes, payload types and cell control types of the frequent-values unit.
`timescale 1ns / 1ps
`default_nettype none
package tkfv_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int MAX_TOP     = 64;

  localparam int VAL_W  = 32;
  localparam int CNT_W  = 16;
  localparam int TOP_W  = 7;
  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int USED_W = IDX_W + 1;
  localparam int N_W    = $clog2(MAX_TOP + 1);
  localparam int CMP_W  = (USED_W > N_W) ? USED_W : N_W;

  typedef struct packed {
    logic signed [VAL_W-1:0] sample_value;
    logic                    set_end;
  } tkfv_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] top_value;
    logic [CNT_W-1:0]        occurrences;
    logic                    final_result;
    logic                    table_overflow;
  } tkfv_out_t;

  // Contents of one cell, also what a cell hands to its neighbor on a rotate.
  typedef struct packed {
    logic                    valid;
    logic                    taken;
    logic signed [VAL_W-1:0] value;
    logic [CNT_W-1:0]        count;
  } tkfv_cell_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic                    clear;
    logic                    sample;
    logic                    hit_any;
    logic signed [VAL_W-1:0] sample_value;
    logic                    rotate;
    logic                    mark;
    logic [IDX_W-1:0]        mark_idx;
  } tkfv_ctrl_t;

endpackage
`default_nettype wire

[rtl/top_k_frequent_values_unit.sv]
// Top level: cell chain, ranking controller and command-style ports of the frequent-values unit.
`timescale 1ns / 1ps
`default_nettype none
// While busy is low the unit takes one sample every cycle: all TABLE_DEPTH cells compare the
// broadcast value at once and either count it, take it into the next free cell or, if the
// table is full, drop it and flag table_overflow. The sample marked set_end raises busy.
// Ranking then rotates the whole chain past one evaluator at its head, one full turn per
// result and then an emit state, and busy stays high until the table is cleared at the end.
// Each result is on out_data for exactly one cycle with out_strobe high and cannot be held
// off; results of one set are separated by a full chain turn.
module top_k_frequent_values_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire tkfv_pkg::tkfv_in_t              in_data,
  output logic                                 out_strobe,
  output tkfv_pkg::tkfv_out_t                  out_data,
  input  wire logic                            cfg_we,
  input  wire logic [tkfv_pkg::TOP_W-1:0]      cfg_data
);
  import tkfv_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_EMIT  = 4'b0100,
    ST_CLEAR = 4'b1000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [TOP_W-1:0]        top_count_r;
  logic [USED_W-1:0]       used_r, used_nxt;
  logic                    overflow_r, overflow_nxt;
  logic [IDX_W-1:0]        pos_r, pos_nxt;
  logic [N_W-1:0]          round_r, round_nxt;
  logic [N_W-1:0]          n_r, n_nxt;
  logic                    found_r, found_nxt;
  logic signed [VAL_W-1:0] best_val_r, best_val_nxt;
  logic [CNT_W-1:0]        best_cnt_r, best_cnt_nxt;
  logic [IDX_W-1:0]        best_idx_r, best_idx_nxt;

  tkfv_ctrl_t              ctrl;
  tkfv_cell_t              cell_q [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]  hit_vec;

  logic                    accept;
  logic                    hit_any;
  logic                    full;
  logic                    insert;
  logic                    take;
  logic                    last_result;
  logic [N_W-1:0]          want;
  logic [CMP_W-1:0]        want_c;
  logic [CMP_W-1:0]        used_c;

  assign busy    = (state_r != ST_IDLE);
  assign accept  = start && !busy;
  assign hit_any = |hit_vec;
  assign full    = cell_q[TABLE_DEPTH-1].valid;
  assign insert  = accept && !hit_any && !full;

  assign want   = (top_count_r > TOP_W'(MAX_TOP)) ? N_W'(MAX_TOP) : N_W'(top_count_r);
  assign want_c = CMP_W'(want);
  assign used_c = CMP_W'(used_nxt);

  // The evaluator sees the cells in table order at the chain head, so a strict compare keeps
  // the earliest value among equal counts.
  assign take = cell_q[0].valid && !cell_q[0].taken &&
                (!found_r || (cell_q[0].count > best_cnt_r));

  assign last_result = (({1'b0, round_r} + 1'b1) == {1'b0, n_r});

  always_comb begin
    ctrl              = '0;
    ctrl.clear        = (state_r == ST_CLEAR);
    ctrl.sample       = accept;
    ctrl.hit_any      = hit_any;
    ctrl.sample_value = in_data.sample_value;
    ctrl.rotate       = (state_r == ST_SCAN);
    ctrl.mark         = (state_r == ST_EMIT);
    ctrl.mark_idx     = best_idx_r;
  end

  genvar gi;
  generate
    for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
      tkfv_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .cell_idx   (IDX_W'(gi)),
        .prev_valid ((gi == 0) ? 1'b1 : cell_q[(gi + TABLE_DEPTH - 1) % TABLE_DEPTH].valid),
        .next_cell  (cell_q[(gi + 1) % TABLE_DEPTH]),
        .cell_q     (cell_q[gi]),
        .hit        (hit_vec[gi])
      );
    end
  endgenerate

  always_comb begin
    state_nxt    = state_r;
    used_nxt     = used_r;
    overflow_nxt = overflow_r;
    pos_nxt      = pos_r;
    round_nxt    = round_r;
    n_nxt        = n_r;
    found_nxt    = found_r;
    best_val_nxt = best_val_r;
    best_cnt_nxt = best_cnt_r;
    best_idx_nxt = best_idx_r;
    case (state_r)
      ST_IDLE: begin
        if (insert) begin
          used_nxt = used_r + 1'b1;
        end
        if (accept && !hit_any && full) begin
          overflow_nxt = 1'b1;
        end
        if (accept && in_data.set_end) begin
          n_nxt     = (want_c < used_c) ? want : N_W'(used_c);
          pos_nxt   = '0;
          round_nxt = '0;
          found_nxt = 1'b0;
          state_nxt = ((want_c < used_c) ? want_c : used_c) == '0 ? ST_CLEAR : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (take) begin
          found_nxt    = 1'b1;
          best_val_nxt = cell_q[0].value;
          best_cnt_nxt = cell_q[0].count;
          best_idx_nxt = pos_r;
        end
        pos_nxt = pos_r + 1'b1;
        // After a full turn the cells are back at their own places.
        if (pos_r == IDX_W'(TABLE_DEPTH - 1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        found_nxt = 1'b0;
        pos_nxt   = '0;
        round_nxt = round_r + 1'b1;
        state_nxt = last_result ? ST_CLEAR : ST_SCAN;
      end
      ST_CLEAR: begin
        used_nxt     = '0;
        overflow_nxt = 1'b0;
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      top_count_r <= TOP_W'(1);
      used_r      <= '0;
      overflow_r  <= 1'b0;
      pos_r       <= '0;
      round_r     <= '0;
      n_r         <= '0;
      found_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      used_r     <= used_nxt;
      overflow_r <= overflow_nxt;
      pos_r      <= pos_nxt;
      round_r    <= round_nxt;
      n_r        <= n_nxt;
      found_r    <= found_nxt;
      if (cfg_we) begin
        top_count_r <= cfg_data;
      end
    end
    best_val_r <= best_val_nxt;
    best_cnt_r <= best_cnt_nxt;
    best_idx_r <= best_idx_nxt;
  end

  assign out_strobe              = (state_r == ST_EMIT);
  assign out_data.top_value      = best_val_r;
  assign out_data.occurrences    = best_cnt_r;
  assign out_data.final_result   = last_result;
  assign out_data.table_overflow = overflow_r;

`ifndef SYNTHESIS
  // A value may sit in at most one cell.
  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> $onehot0(hit_vec))
    else $error("sample value matched more than one cell");

  // No two result beats come back to back.
  a_strobe_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("two result beats in consecutive cycles");

  // The end of a set always starts ranking or clearing.
  a_set_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.set_end) |=> busy)
    else $error("unit not busy after the last sample of a set");

  // Every emitted result comes from a cell that was found in the scan.
  a_emit_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (found_r && (used_r != '0)))
    else $error("result beat without a selected cell");
`endif

endmodule
`default_nettype wire

[rtl/tkfv_cell.sv]
// One table cell: holds a value, its count and flags, and shifts toward the chain head on rotate.
`timescale 1ns / 1ps
`default_nettype none
module tkfv_cell (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire tkfv_pkg::tkfv_ctrl_t      ctrl,
  input  wire logic [tkfv_pkg::IDX_W-1:0] cell_idx,
  input  wire logic                      prev_valid,
  input  wire tkfv_pkg::tkfv_cell_t      next_cell,
  output tkfv_pkg::tkfv_cell_t           cell_q,
  output logic                           hit
);
  import tkfv_pkg::*;

  tkfv_cell_t cell_r;
  tkfv_cell_t cell_nxt;

  assign hit    = cell_r.valid && (cell_r.value == ctrl.sample_value);
  assign cell_q = cell_r;

  always_comb begin
    cell_nxt = cell_r;
    if (ctrl.clear) begin
      cell_nxt.valid = 1'b0;
      cell_nxt.taken = 1'b0;
    end else if (ctrl.sample) begin
      if (hit) begin
        if (cell_r.count != {CNT_W{1'b1}}) begin
          cell_nxt.count = cell_r.count + 1'b1;
        end
      end else if (!cell_r.valid && prev_valid && !ctrl.hit_any) begin
        // Cells fill in order, so the first free cell is the one after the last valid one.
        cell_nxt.valid = 1'b1;
        cell_nxt.taken = 1'b0;
        cell_nxt.value = ctrl.sample_value;
        cell_nxt.count = {{(CNT_W-1){1'b0}}, 1'b1};
      end
    end else if (ctrl.rotate) begin
      cell_nxt = next_cell;
    end else if (ctrl.mark && (ctrl.mark_idx == cell_idx)) begin
      cell_nxt.taken = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
      cell_r.taken <= 1'b0;
    end else begin
      cell_r.valid <= cell_nxt.valid;
      cell_r.taken <= cell_nxt.taken;
    end
    cell_r.value <= cell_nxt.value;
    cell_r.count <= cell_nxt.count;
  end

endmodule
`default_nettype wire

[dv/tb_top_k_frequent_values_unit.sv]
// Self-checking testbench for the frequent-values unit: a directed table and random sets.
`timescale 1ns / 1ps
module tb_top_k_frequent_values_unit;
  import tkfv_pkg::*;

  localparam int          RUN_LIMIT     = 200_000;
  localparam int          SETTLE_CYCLES = 4;
  localparam logic [15:0] COUNT_CEIL    = 16'hFFFF;
  localparam tkfv_out_t   NO_RANK       = '0;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e               kind;
    logic signed [VAL_W-1:0] value;
    logic                    last;
    logic                    typed;
    tkfv_out_t               want;
    logic [TOP_W-1:0]        cfg_value;
  } row_t;

  localparam int SCRIPT_ROWS = 31;

  // Rows with typed set to one carry their single result written out by hand.
  row_t script [SCRIPT_ROWS] = '{
    '{ROW_BEAT, 32'sh7FFF_FFFF, 1'b1, 1'b1, '{32'sh7FFF_FFFF, 16'd1, 1'b1, 1'b0}, 7'd0},
    '{ROW_BEAT, 32'sh8000_0000, 1'b0, 1'b0, NO_RANK, 7'd0},
    '{ROW_BEAT, 32'sh8000_0000, 1'b0, 1'b0, NO_RANK, 7'd0},
    '{ROW_BEAT, 32'sh0000_0000, 1'b1, 1'b1, '{32'sh8000_0000, 16'd2, 1'b1, 1'b0}, 7'd0},
    // A tie goes to the value that showed up first.
    '{ROW_BEAT, 32'sh0000_0005, 1'b0, 1'b0, NO_RANK, 7'd0},
    '{ROW_BEAT, 32'shFFFF_FFFF, 1'b0, 1'b0, NO_RANK, 7'd0},
    '{ROW_BEAT, 32'shFFFF_FFFF, 1'b0, 1'b0, NO_RANK, 7'd0},
    '{ROW_BEAT, 32'sh0000_0005, 1'b1, 1'b1, '{32'sh0000_0005, 16'd2, 1'b1, 1'b0}, 7'd0},
    '{ROW_CFG,  32'sh0000_0000, 1'b0, 1'b0, NO_RANK, 7'd64},
    '{ROW_BEAT, 32'sh0000_0000, 1'b0, 1'b0, NO_RANK, 7'd0},
    '{ROW_BEAT, 32'sh0000_0001, 1'b0, 1'b0, NO_RANK, 7'd0},
    '{ROW_BEAT, 32'sh0000_0001, 1'b0, 1'b0, NO_RANK, 7'd0},
    '{ROW_BEAT, 32'shAAAA_5555, 1'b0, 1'b0, NO_RANK, 7'd0},
    '{ROW_BEAT, 32'sh5555_AAAA, 1'b0, 1'b0, NO_RANK, 7'd0},
    '{ROW_BEAT, 32'sh0000_0001, 1'b0, 1'b0, NO_RANK, 7'd0},
    '{ROW_BEAT, 32'shFFFF_FFFF, 1'b1, 1'b0, NO_RANK, 7'd0},
    // With a count of zero the set ends silently.
    '{ROW_CFG,  32'sh0000_0000, 1'b0, 1'b0, NO_RANK, 7'd0},
    '{ROW_BEAT, 32'sh0000_0009, 1'b0, 1'b0, NO_RANK, 7'd0},
    '{ROW_BEAT, 32'sh0000_0009, 1'b1, 1'b0, NO_RANK, 7'd0},
    '{ROW_CFG,  32'sh0000_0000, 1'b0, 1'b0, NO_RANK, 7'd127},
    '{ROW_BEAT, 32'sh0000_0003, 1'b0, 1'b0, NO_RANK, 7'd0},
    '{ROW_BEAT, 32'shFFFF_FFFD, 1'b1, 1'b0, NO_RANK, 7'd0},
    '{ROW_CFG,  32'sh0000_0000, 1'b0, 1'b0, NO_RANK, 7'd65},
    '{ROW_BEAT, 32'sh1234_5678, 1'b0, 1'b0, NO_RANK, 7'd0},
    '{ROW_BEAT, 32'sh1234_5678, 1'b1, 1'b0, NO_RANK, 7'd0},
    '{ROW_CFG,  32'sh0000_0000, 1'b0, 1'b0, NO_RANK, 7'd2},
    '{ROW_BEAT, 32'sh0000_0004, 1'b0, 1'b0, NO_RANK, 7'd0},
    '{ROW_BEAT, 32'sh0000_0008, 1'b0, 1'b0, NO_RANK, 7'd0},
    '{ROW_BEAT, 32'sh0000_0008, 1'b0, 1'b0, NO_RANK, 7'd0},
    '{ROW_BEAT, 32'sh0000_0004, 1'b0, 1'b0, NO_RANK, 7'd0},
    '{ROW_BEAT, 32'sh0000_0006, 1'b1, 1'b0, NO_RANK, 7'd0}
  };

  logic              clk = 1'b0;
  logic              rst_n;
  logic              start;
  logic              busy;
  tkfv_in_t          in_data;
  logic              out_strobe;
  tkfv_out_t         out_data;
  logic              cfg_we;
  logic [TOP_W-1:0]  cfg_data;

  // Shadow of the value table and of the report length.
  logic signed [VAL_W-1:0] freq_value [TABLE_DEPTH];
  logic [CNT_W-1:0]        freq_count [TABLE_DEPTH];
  int                      freq_used;
  logic                    freq_dropped;
  logic [TOP_W-1:0]        report_len;

  tkfv_out_t fresh_ranks [$];
  tkfv_out_t pending_ranks [$];
  tkfv_out_t oldest_rank;

  int mismatches;
  int ranks_seen;
  int beats_sent;
  int sets_sent;
  int cycle_count;

  logic signed [VAL_W-1:0] extremes [4] = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, -32'sd1};
  int                      idle_plan [4] = '{0, 78, 20, 0};
  logic signed [VAL_W-1:0] pool [5];
  logic signed [VAL_W-1:0] value;
  int                      phase;
  int                      phase_beats;
  int                      rand_beats;
  int                      set_len;
  int                      idle_pct;
  int                      pick;

  top_k_frequent_values_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic flag_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    mismatches++;
  endtask

  // Counts one sample into the shadow table; on the last beat of a set it ranks the table
  // into fresh_ranks and clears it.
  function automatic void tally_and_rank(input tkfv_in_t beat);
    int        hit;
    int        want_n;
    int        n;
    int        best;
    bit        taken [TABLE_DEPTH];
    tkfv_out_t rank;
    hit = -1;
    for (int i = 0; i < freq_used; i++) begin
      if (freq_value[i] == beat.sample_value) hit = i;
    end
    if (hit >= 0) begin
      if (freq_count[hit] != COUNT_CEIL) freq_count[hit]++;
    end else if (freq_used < TABLE_DEPTH) begin
      freq_value[freq_used] = beat.sample_value;
      freq_count[freq_used] = CNT_W'(1);
      freq_used++;
    end else begin
      freq_dropped = 1'b1;
    end
    if (!beat.set_end) return;
    want_n = (report_len > MAX_TOP) ? MAX_TOP : int'(report_len);
    n = (want_n < freq_used) ? want_n : freq_used;
    for (int r = 0; r < n; r++) begin
      best = -1;
      for (int i = 0; i < freq_used; i++) begin
        if (!taken[i] && (best < 0 || freq_count[i] > freq_count[best])) best = i;
      end
      taken[best] = 1'b1;
      rank.top_value      = freq_value[best];
      rank.occurrences    = freq_count[best];
      rank.final_result   = (r == n - 1);
      rank.table_overflow = freq_dropped;
      fresh_ranks = {fresh_ranks, rank};
    end
    freq_used    = 0;
    freq_dropped = 1'b0;
  endfunction

  // Offers one sample beat, waits for busy low at a clock edge, then records what it should cause.
  task automatic send_sample(input logic signed [VAL_W-1:0] sample, input logic last,
                             input int idle, input logic typed = 1'b0,
                             input tkfv_out_t typed_rank = '0);
    int       gap;
    tkfv_in_t beat;
    gap = ($urandom_range(99) < idle) ? $urandom_range(1, 4) : 0;
    beat.sample_value = sample;
    beat.set_end      = last;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= beat;
    @(posedge clk);
    while (busy) @(posedge clk);
    fresh_ranks.delete();
    tally_and_rank(beat);
    if (typed) begin
      pending_ranks = {pending_ranks, typed_rank};
    end else begin
      pending_ranks = {pending_ranks, fresh_ranks};
    end
    beats_sent++;
    if (last) sets_sent++;
  endtask

  // The register is only touched once the ranking of the previous set has fully drained.
  task automatic write_top_count(input logic [TOP_W-1:0] count);
    start <= 1'b0;
    while (pending_ranks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= count;
    @(posedge clk);
    cfg_we     <= 1'b0;
    report_len  = count;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_ranks.size() == 0) begin
        flag_mismatch($sformatf("unexpected result value %0d count %0d",
                                out_data.top_value, out_data.occurrences));
      end else begin
        oldest_rank = pending_ranks.pop_front();
        ranks_seen++;
        if (out_data.top_value !== oldest_rank.top_value)
          flag_mismatch($sformatf("top_value %0d, expected %0d",
                                  out_data.top_value, oldest_rank.top_value));
        if (out_data.occurrences !== oldest_rank.occurrences)
          flag_mismatch($sformatf("occurrences %0d, expected %0d",
                                  out_data.occurrences, oldest_rank.occurrences));
        if (out_data.final_result !== oldest_rank.final_result)
          flag_mismatch($sformatf("final_result %b, expected %b",
                                  out_data.final_result, oldest_rank.final_result));
        if (out_data.table_overflow !== oldest_rank.table_overflow)
          flag_mismatch($sformatf("table_overflow %b, expected %b",
                                  out_data.table_overflow, oldest_rank.table_overflow));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending_ranks.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    cycle_count  = 0;
    mismatches   = 0;
    ranks_seen   = 0;
    beats_sent   = 0;
    sets_sent    = 0;
    rand_beats   = 0;
    freq_used    = 0;
    freq_dropped = 1'b0;
    report_len   = 7'd1;
    rst_n    <= 1'b0;
    start    <= 1'b0;
    in_data  <= '0;
    cfg_we   <= 1'b0;
    cfg_data <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[r]) begin
      if (script[r].kind == ROW_CFG) write_top_count(script[r].cfg_value);
      else send_sample(script[r].value, script[r].last, 0, script[r].typed, script[r].want);
    end

    phase = 0;
    while (rand_beats < 84) begin
      idle_pct = idle_plan[phase % 4];
      pick = $urandom_range(9);
      write_top_count(pick == 0 ? 7'd0 :
                      pick == 1 ? 7'($urandom_range(64, 127)) : 7'($urandom_range(1, 6)));
      phase_beats = 0;
      while (phase_beats < 21) begin
        set_len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        foreach (pool[p]) pool[p] = ($urandom_range(7) == 0) ? extremes[$urandom_range(3)]
                                                             : $urandom;
        for (int j = 0; j < set_len; j++) begin
          value = ($urandom_range(9) < 7) ? pool[$urandom_range(4)] : $urandom;
          send_sample(value, j == set_len - 1, idle_pct);
        end
        phase_beats += set_len;
        rand_beats  += set_len;
      end
      phase++;
    end

    start <= 1'b0;
    while (pending_ranks.size() != 0) @(posedge clk);
    repeat (TABLE_DEPTH + 8) @(posedge clk);
    $display("Sent %0d sample beats in %0d sets and checked %0d ranked results.",
             beats_sent, sets_sent, ranks_seen);
    $display("Covered top_count 0, 1, 64 and above, ties, extreme values and sender gaps.");
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/tkfv_pkg.sv
rtl/tkfv_cell.sv
rtl/top_k_frequent_values_unit.sv
dv/tb_top_k_frequent_values_unit.sv
